// File: rtl/mrfc_pkg.sv
// Shared types, constants and functions for the Modbus RTU frame checker.
package mrfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATION_ADDRESS = 1'b0,
    CFG_DEVICE_KIND     = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ADDR_ERR   = 2'd1,
    STATUS_CRC_ERR    = 2'd2,
    STATUS_HEADER_ERR = 2'd3
  } frame_status_t;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_FN04     = 3'd1,
    KIND_FN43     = 3'd2,
    KIND_FN02     = 3'd3,
    KIND_FN51     = 3'd4
  } device_kind_t;

  localparam logic [7:0] FN_READ_INPUT = 8'h04;
  localparam logic [7:0] FN_ENCAP      = 8'h43;
  localparam logic [7:0] FN_READ_DISC  = 8'h02;
  localparam logic [7:0] FN_CUSTOM     = 8'h51;
  localparam logic [7:0] LEN_TEN       = 8'h10;
  localparam logic [7:0] MEI_BYTE2     = 8'h00;
  localparam logic [7:0] MEI_BYTE3     = 8'h18;

  localparam logic [2:0] POS_SAT = 3'd4;

  typedef logic [7:0] byte_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic header_ok(input logic [2:0] kind, input byte_t h0,
                                     input byte_t h1, input byte_t h2);
    logic ok;
    case (kind)
      KIND_FN04: ok = (h0 == FN_READ_INPUT) && (h1 == LEN_TEN);
      KIND_FN43: ok = (h0 == FN_ENCAP) && (h1 == MEI_BYTE2) && (h2 == MEI_BYTE3);
      KIND_FN02: ok = (h0 == FN_READ_DISC) && (h1 == LEN_TEN);
      KIND_FN51: ok = (h0 == FN_CUSTOM) && (h1 == LEN_TEN);
      default:   ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

// File: rtl/modbus_rtu_frame_checker.sv
// Modbus RTU frame checker: CRC-16/Modbus, station address and header check.
//
// Usage:
//   Feed the frame one byte per item on the in_ channel (in_rx_byte), with
//   in_last_byte high on the final byte. Each frame yields one item on the
//   out_ channel carrying out_frame_status: 0 ok, 1 address mismatch,
//   2 CRC error, 3 header mismatch (first failing check wins).
//   The last two frame bytes are the CRC, low byte first.
//   Configure station address (index 0) and device kind (index 1) through
//   cfg_we/cfg_index/cfg_wdata while no frame is in progress.
// Timing:
//   One item per cycle while no status waits on out_ready. The status is
//   registered: it appears on out_valid in the cycle after the final byte
//   is accepted. The byte-wide CRC update of the held byte and the trailer
//   compare sit between the frame state registers and the status register.
// Reset:
//   Synchronous active-low rst_n clears registers, frame state and the
//   output; the block accepts bytes in the first cycle after reset.
// Stall:
//   While a status waits on a low out_ready, in_ready is low and bytes hold;
//   input resumes in the cycle in which out_ready rises.
module modbus_rtu_frame_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mrfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             in_last_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_frame_status
);

  logic [7:0]  station_r;
  logic [2:0]  kind_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  hdr0_r, hdr0_nxt;
  logic [7:0]  hdr1_r, hdr1_nxt;
  logic [7:0]  hdr2_r, hdr2_nxt;
  logic        am_r, am_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        accept;
  logic [15:0] crc_upd;
  logic        am_cur;
  logic [7:0]  h0_cur, h1_cur, h2_cur;
  mrfc_pkg::frame_status_t st;

  assign in_ready         = !out_valid_r || out_ready;
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_frame_status = status_r;

  always_comb begin
    am_cur = am_r;
    h0_cur = hdr0_r;
    h1_cur = hdr1_r;
    h2_cur = hdr2_r;
    case (pos_r)
      3'd0: begin
        am_cur = (in_rx_byte == station_r);
        h0_cur = 8'h00;
        h1_cur = 8'h00;
        h2_cur = 8'h00;
      end
      3'd1: h0_cur = in_rx_byte;
      3'd2: h1_cur = in_rx_byte;
      3'd3: h2_cur = in_rx_byte;
      default: ;
    endcase

    crc_upd = (pos_r >= 3'd2) ? mrfc_pkg::crc_feed(crc_r, held0_r) : crc_r;

    if (!am_cur) begin
      st = mrfc_pkg::STATUS_ADDR_ERR;
    end else if (pos_r == 3'd0) begin
      st = mrfc_pkg::STATUS_CRC_ERR;
    end else if (held1_r != crc_upd[7:0] || in_rx_byte != crc_upd[15:8]) begin
      st = mrfc_pkg::STATUS_CRC_ERR;
    end else if (!mrfc_pkg::header_ok(kind_r, h0_cur, h1_cur, h2_cur)) begin
      st = mrfc_pkg::STATUS_HEADER_ERR;
    end else begin
      st = mrfc_pkg::STATUS_OK;
    end

    crc_nxt       = crc_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    pos_nxt       = pos_r;
    hdr0_nxt      = hdr0_r;
    hdr1_nxt      = hdr1_r;
    hdr2_nxt      = hdr2_r;
    am_nxt        = am_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (accept) begin
      if (in_last_byte) begin
        crc_nxt       = mrfc_pkg::CRC_INIT;
        held0_nxt     = 8'h00;
        held1_nxt     = 8'h00;
        pos_nxt       = 3'd0;
        hdr0_nxt      = 8'h00;
        hdr1_nxt      = 8'h00;
        hdr2_nxt      = 8'h00;
        am_nxt        = 1'b0;
        status_nxt    = st;
        out_valid_nxt = 1'b1;
      end else begin
        crc_nxt   = crc_upd;
        held0_nxt = held1_r;
        held1_nxt = in_rx_byte;
        pos_nxt   = (pos_r < mrfc_pkg::POS_SAT) ? pos_r + 3'd1 : pos_r;
        hdr0_nxt  = h0_cur;
        hdr1_nxt  = h1_cur;
        hdr2_nxt  = h2_cur;
        am_nxt    = am_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r   <= 8'h00;
      kind_r      <= 3'd0;
      crc_r       <= mrfc_pkg::CRC_INIT;
      held0_r     <= 8'h00;
      held1_r     <= 8'h00;
      pos_r       <= 3'd0;
      hdr0_r      <= 8'h00;
      hdr1_r      <= 8'h00;
      hdr2_r      <= 8'h00;
      am_r        <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= mrfc_pkg::STATUS_OK;
    end else begin
      if (cfg_we) begin
        case (mrfc_pkg::cfg_index_t'(cfg_index))
          mrfc_pkg::CFG_STATION_ADDRESS: station_r <= cfg_wdata;
          mrfc_pkg::CFG_DEVICE_KIND:     kind_r    <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      crc_r       <= crc_nxt;
      held0_r     <= held0_nxt;
      held1_r     <= held1_nxt;
      pos_r       <= pos_nxt;
      hdr0_r      <= hdr0_nxt;
      hdr1_r      <= hdr1_nxt;
      hdr2_r      <= hdr2_nxt;
      am_r        <= am_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

endmodule
